### rtl/sivde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sivde_pkg
// Shared types and constants of the signed integer binary/decimal encoder.
// ----------------------------------------------------------------------------
package sivde_pkg;

    localparam int VALUE_W     = 32;
    localparam int MAG_W       = 31;
    localparam int BYTE_W      = 8;
    localparam int BCNT_W      = 3;
    localparam int DCNT_W      = 4;
    localparam int MAX_DIGITS  = 10;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;
    localparam int PROD_W      = 63;
    localparam int RECIP_SHIFT = 35;

    localparam logic [31:0]       RECIP_10       = 32'hCCCC_CCCD;
    localparam logic [BYTE_W-1:0] NEG_HDR_OFFSET = 8'd5;
    localparam logic [BYTE_W-1:0] CHAR_ZERO      = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_SPACE     = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_MINUS     = 8'h2D;

    typedef struct packed {
        logic             neg;
        logic             binary_mode;
        logic [MAG_W-1:0] mag;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIN_HDR,
        ST_BIN_BYTE,
        ST_TXT_DIV,
        ST_TXT_SIGN,
        ST_TXT_DIGIT,
        ST_TXT_SPACE
    } t_back_state;

endpackage

### rtl/sivde_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sivde interfaces
// Valid/ready channels for input values, output bytes and configuration.
// ----------------------------------------------------------------------------
interface sivde_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [sivde_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sivde_out_if;
    logic                        valid;
    logic                        ready;
    logic [sivde_pkg::BYTE_W-1:0] out_byte;
    logic                        last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

interface sivde_cfg_if;
    logic valid;
    logic ready;
    logic binary_mode;

    modport source (output valid, output binary_mode, input ready);
    modport sink   (input valid, input binary_mode, output ready);
endinterface

### rtl/sivde_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sivde_front
// Holds the mode register, accepts values and forms sign and clamped magnitude.
// ----------------------------------------------------------------------------
module sivde_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sivde_in_if.sink             i_in,
    sivde_cfg_if.sink            i_cfg,
    output logic                 o_push_valid,
    output sivde_pkg::t_item     o_push_item,
    input  logic                 i_push_ready
);

    logic                              r_binary_mode;
    logic [sivde_pkg::VALUE_W-1:0]     raw;
    logic [sivde_pkg::VALUE_W-1:0]     abs_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_binary_mode <= 1'b1;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_binary_mode <= i_cfg.binary_mode;
        end
    end

    assign i_cfg.ready = 1'b1;
    assign raw         = i_in.value;
    assign abs_val     = raw[sivde_pkg::VALUE_W-1] ? (~raw + 32'd1) : raw;

    // most negative value clamps to the largest positive magnitude
    always_comb begin
        o_push_item.neg         = raw[sivde_pkg::VALUE_W-1];
        o_push_item.binary_mode = r_binary_mode;
        o_push_item.mag         = abs_val[sivde_pkg::VALUE_W-1] ? {sivde_pkg::MAG_W{1'b1}}
                                                                : abs_val[sivde_pkg::MAG_W-1:0];
    end

    assign o_push_valid = i_in.valid;
    assign i_in.ready   = i_push_ready;

endmodule

### rtl/sivde_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sivde_queue
// Two-entry queue of classified values between front and back.
// ----------------------------------------------------------------------------
module sivde_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    input  sivde_pkg::t_item i_push_item,
    output logic             o_push_ready,
    output logic             o_pop_valid,
    output sivde_pkg::t_item o_pop_item,
    input  logic             i_pop_ready
);

    sivde_pkg::t_item                r_mem [sivde_pkg::QUEUE_DEPTH];
    logic [sivde_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [sivde_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [sivde_pkg::QCNT_W-1:0]    r_count;
    logic                            push;
    logic                            pop;

    assign o_push_ready = (r_count != sivde_pkg::QCNT_W'(sivde_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/sivde_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sivde_back
// Encodes one value at a time into bytes: binary header and magnitude bytes,
// or sign, decimal digits and a trailing space.
// ----------------------------------------------------------------------------
module sivde_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_item_valid,
    input  sivde_pkg::t_item i_item,
    output logic             o_item_ready,
    sivde_out_if.source      o_out
);

    sivde_pkg::t_back_state          r_state, n_state;
    logic                            r_neg, n_neg;
    logic [sivde_pkg::MAG_W-1:0]     r_mag, n_mag;
    logic [sivde_pkg::BCNT_W-1:0]    r_bidx, n_bidx;
    logic [sivde_pkg::DCNT_W-1:0]    r_dcnt, n_dcnt;
    logic                            r_out_valid, n_out_valid;
    logic [sivde_pkg::BYTE_W-1:0]    r_out_byte, n_out_byte;
    logic                            r_out_last, n_out_last;
    logic [3:0]                      r_digit_store [sivde_pkg::MAX_DIGITS];

    logic                            out_free;
    logic [sivde_pkg::BCNT_W-1:0]    in_bcnt;
    logic [sivde_pkg::PROD_W-1:0]    prod;
    logic [sivde_pkg::MAG_W-1:0]     quot;
    logic [3:0]                      rem;
    logic [sivde_pkg::DCNT_W-1:0]    dcnt_m1;
    logic [sivde_pkg::BYTE_W-1:0]    mag_byte;
    logic                            dig_we;

    assign out_free     = !r_out_valid || o_out.ready;
    assign o_item_ready = (r_state == sivde_pkg::ST_IDLE);

    // divide by ten through the reciprocal, remainder from the low nibble
    assign prod    = sivde_pkg::PROD_W'(r_mag) * sivde_pkg::PROD_W'(sivde_pkg::RECIP_10);
    assign quot    = sivde_pkg::MAG_W'(prod[sivde_pkg::PROD_W-1:sivde_pkg::RECIP_SHIFT]);
    assign rem     = r_mag[3:0] - ({quot[2:0], 1'b0} + {quot[0], 3'b000});
    assign dcnt_m1 = r_dcnt - 4'd1;

    always_comb begin
        if (|i_item.mag[30:24]) begin
            in_bcnt = 3'd4;
        end else if (|i_item.mag[23:16]) begin
            in_bcnt = 3'd3;
        end else if (|i_item.mag[15:8]) begin
            in_bcnt = 3'd2;
        end else if (|i_item.mag[7:0]) begin
            in_bcnt = 3'd1;
        end else begin
            in_bcnt = 3'd0;
        end
    end

    always_comb begin
        case (r_bidx)
            3'd4:    mag_byte = {1'b0, r_mag[30:24]};
            3'd3:    mag_byte = r_mag[23:16];
            3'd2:    mag_byte = r_mag[15:8];
            3'd1:    mag_byte = r_mag[7:0];
            default: mag_byte = '0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_bidx      = r_bidx;
        n_dcnt      = r_dcnt;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        dig_we      = 1'b0;
        case (r_state)
            sivde_pkg::ST_IDLE: begin
                if (i_item_valid) begin
                    n_neg  = i_item.neg;
                    n_mag  = i_item.mag;
                    n_bidx = in_bcnt;
                    n_dcnt = '0;
                    n_state = i_item.binary_mode ? sivde_pkg::ST_BIN_HDR
                                                 : sivde_pkg::ST_TXT_DIV;
                end
            end
            sivde_pkg::ST_BIN_HDR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = sivde_pkg::BYTE_W'(r_bidx)
                                + (r_neg ? sivde_pkg::NEG_HDR_OFFSET : 8'd0);
                    n_out_last  = (r_bidx == 3'd0);
                    n_state     = (r_bidx == 3'd0) ? sivde_pkg::ST_IDLE
                                                   : sivde_pkg::ST_BIN_BYTE;
                end
            end
            sivde_pkg::ST_BIN_BYTE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = mag_byte;
                    n_out_last  = (r_bidx == 3'd1);
                    n_bidx      = r_bidx - 3'd1;
                    if (r_bidx == 3'd1) begin
                        n_state = sivde_pkg::ST_IDLE;
                    end
                end
            end
            sivde_pkg::ST_TXT_DIV: begin
                dig_we = 1'b1;
                n_dcnt = r_dcnt + 4'd1;
                n_mag  = quot;
                if (quot == '0) begin
                    n_state = r_neg ? sivde_pkg::ST_TXT_SIGN : sivde_pkg::ST_TXT_DIGIT;
                end
            end
            sivde_pkg::ST_TXT_SIGN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = sivde_pkg::CHAR_MINUS;
                    n_out_last  = 1'b0;
                    n_state     = sivde_pkg::ST_TXT_DIGIT;
                end
            end
            sivde_pkg::ST_TXT_DIGIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = sivde_pkg::CHAR_ZERO + {4'd0, r_digit_store[dcnt_m1]};
                    n_out_last  = 1'b0;
                    n_dcnt      = dcnt_m1;
                    if (r_dcnt == 4'd1) begin
                        n_state = sivde_pkg::ST_TXT_SPACE;
                    end
                end
            end
            sivde_pkg::ST_TXT_SPACE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = sivde_pkg::CHAR_SPACE;
                    n_out_last  = 1'b1;
                    n_state     = sivde_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sivde_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sivde_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_bidx      <= '0;
            r_dcnt      <= '0;
            r_mag       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_bidx      <= n_bidx;
            r_dcnt      <= n_dcnt;
            r_mag       <= n_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg      <= n_neg;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        if (dig_we) begin
            r_digit_store[r_dcnt] <= rem;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.last     = r_out_last;

endmodule

### rtl/signed_int_varint_or_decimal_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_varint_or_decimal_encoder_top
// Encodes signed 32-bit values as length-prefixed binary or decimal text bytes.
// ----------------------------------------------------------------------------
// i_in carries one signed value per transaction; o_out returns one byte per
// transaction with last set on the final byte of each value. i_cfg writes the
// binary_mode bit (1 binary, 0 text); it is always ready and should only be
// written while the block is idle. The mode is sampled when a value is taken.
// The front takes a value whenever the two-entry queue has room, so input is
// taken while the back still encodes or a byte waits in the output register.
// Binary mode: the back fetches a value from the queue, then emits header and
// magnitude bytes. Text mode: after the fetch the divide-by-ten unit (multiply
// by reciprocal) forms one decimal digit per cycle, then sign, digits and space
// go out. Bytes leave one per cycle while the receiver keeps up, and the back
// takes a new value only when through with the last. Reset restores binary
// mode and empties the queue and output register. A stalled receiver holds the
// output byte and the back, then fills the queue, then deasserts i_in.ready.
// ----------------------------------------------------------------------------
module signed_int_varint_or_decimal_encoder_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sivde_in_if.sink     i_in,
    sivde_cfg_if.sink    i_cfg,
    sivde_out_if.source  o_out
);

    logic             push_valid;
    logic             push_ready;
    sivde_pkg::t_item push_item;
    logic             pop_valid;
    logic             pop_ready;
    sivde_pkg::t_item pop_item;

    sivde_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (i_cfg),
        .o_push_valid (push_valid),
        .o_push_item  (push_item),
        .i_push_ready (push_ready)
    );

    sivde_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_item  (push_item),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_item   (pop_item),
        .i_pop_ready  (pop_ready)
    );

    sivde_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (pop_valid),
        .i_item       (pop_item),
        .o_item_ready (pop_ready),
        .o_out        (o_out)
    );

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the signed integer encoder in binary and decimal text mode. Each
// value taken on the input channel is encoded by a local predictor into the
// bytes it should produce, and every output transaction is compared with the
// oldest byte still awaited. Directed extremes come first. Random traffic
// follows under changing idle patterns, with mode writes between phases, a
// long output stall, and a pause of the sender until all bytes have come.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic MODE_TEXT   = 1'b0;
    localparam logic MODE_BINARY = 1'b1;
    localparam int   MAX_BYTES   = 12;
    localparam int   STALL_LIMIT = 4000;
    localparam int   HOLD_CYCLES = 250;

    typedef struct {
        logic [sivde_pkg::BYTE_W-1:0] out_byte;
        logic                         last;
        logic signed [31:0]           value;
    } t_enc_byte;

    logic i_clk;
    logic i_rst_n;

    sivde_in_if  in_if();
    sivde_out_if out_if();
    sivde_cfg_if cfg_if();

    signed_int_varint_or_decimal_encoder_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    t_enc_byte expected_bytes[$];
    logic      mode_bin;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_request;
    int        hold_left;
    int        errors;
    int        quiet_cycles;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // byte sequence that one value should produce
    function automatic void encode_value(input logic signed [31:0] v, input logic bin);
        logic [sivde_pkg::BYTE_W-1:0] enc [MAX_BYTES];
        logic [3:0]                   digits [sivde_pkg::MAX_DIGITS];
        logic [31:0]                  mag;
        logic [31:0]                  rest;
        logic                         neg;
        int                           n;
        int                           cnt;
        int                           nd;
        t_enc_byte                    e;
        n = 0;
        neg = v[31];
        mag = neg ? (~v + 32'd1) : v;
        if (mag > 32'h7FFF_FFFF) begin
            mag = 32'h7FFF_FFFF;
        end
        if (bin) begin
            if (mag[31:24] != 0) cnt = 4;
            else if (mag[23:16] != 0) cnt = 3;
            else if (mag[15:8] != 0) cnt = 2;
            else if (mag[7:0] != 0) cnt = 1;
            else cnt = 0;
            enc[n] = neg ? sivde_pkg::BYTE_W'(cnt) + sivde_pkg::NEG_HDR_OFFSET
                         : sivde_pkg::BYTE_W'(cnt);
            n++;
            for (int i = cnt; i > 0; i--) begin
                enc[n] = mag[(i-1)*8 +: 8];
                n++;
            end
        end else begin
            if (neg) begin
                enc[n] = sivde_pkg::CHAR_MINUS;
                n++;
            end
            rest = mag;
            nd = 0;
            do begin
                digits[nd] = 4'(rest % 10);
                nd++;
                rest = rest / 10;
            end while (rest > 0);
            for (int i = nd - 1; i >= 0; i--) begin
                enc[n] = sivde_pkg::CHAR_ZERO + sivde_pkg::BYTE_W'(digits[i]);
                n++;
            end
            enc[n] = sivde_pkg::CHAR_SPACE;
            n++;
        end
        for (int i = 0; i < n; i++) begin
            e.out_byte = enc[i];
            e.last = (i == n - 1);
            e.value = v;
            expected_bytes.push_back(e);
        end
    endfunction

    function automatic logic signed [31:0] random_value();
        logic [31:0] v;
        int          width;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0: v = 32'h0000_0000;
                    1: v = 32'hFFFF_FFFF;
                    2: v = 32'h7FFF_FFFF;
                    3: v = 32'h8000_0000;
                    4: v = 32'h8000_0001;
                    default: v = 32'h0000_0001;
                endcase
            end
            default: begin
                width = $urandom_range(0, 32);
                v = (width == 0) ? 32'd0 : ($urandom() >> (32 - width));
                if ($urandom_range(0, 1)) begin
                    v = ~v + 32'd1;
                end
            end
        endcase
        return v;
    endfunction

    task automatic send_value(input logic signed [31:0] v);
        @(negedge i_clk);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        in_if.valid = 1'b1;
        in_if.value = v;
        do @(posedge i_clk); while (!in_if.ready);
        encode_value(v, mode_bin);
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.binary_mode = m;
        do @(posedge i_clk); while (!cfg_if.ready);
        mode_bin = m;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic test_binary_directed();
        logic signed [31:0] vals [13];
        vals = '{32'sh0000_0000, 32'sh0000_0001, 32'shFFFF_FFFF, 32'sh0000_00FF,
                 32'sh0000_0100, 32'shFFFF_FF00, 32'sh0000_FFFF, 32'sh0001_0000,
                 32'sh00FF_FFFF, 32'sh0100_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                 32'sh8000_0001};
        foreach (vals[i]) send_value(vals[i]);
        wait_for_drain();
    endtask

    task automatic test_text_directed();
        logic signed [31:0] vals [12];
        vals = '{32'sd0, 32'sd9, 32'sd10, -32'sd1, -32'sd9, 32'sd99, 32'sd100,
                 32'sd999999999, 32'sd1000000000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                 32'sh8000_0001};
        write_mode(MODE_TEXT);
        foreach (vals[i]) send_value(vals[i]);
        wait_for_drain();
    endtask

    task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        write_mode(MODE_TEXT);
        repeat (n / 2) send_value(random_value());
        wait_for_drain();
        write_mode(MODE_BINARY);
        repeat (n - n / 2) send_value(random_value());
        wait_for_drain();
    endtask

    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_mode(MODE_TEXT);
        hold_request = HOLD_CYCLES;
        repeat (16) send_value(random_value());
        wait_for_drain();
    endtask

    // receiver: random ready, or a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            out_if.ready = 1'b0;
            hold_left--;
        end else begin
            out_if.ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_enc_byte e;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_bytes.size() == 0) begin
                $error("out_byte: expected none, actual %02h", out_if.out_byte);
                errors++;
            end else begin
                e = expected_bytes.pop_front();
                if (out_if.out_byte !== e.out_byte) begin
                    $error("out_byte: expected %02h, actual %02h (value %0d)",
                           e.out_byte, out_if.out_byte, e.value);
                    errors++;
                end
                if (out_if.last !== e.last) begin
                    $error("last: expected %0b, actual %0b (value %0d)",
                           e.last, out_if.last, e.value);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("signed_int_varint_or_decimal_encoder_top: mismatch");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.value = '0;
        cfg_if.valid = 1'b0;
        cfg_if.binary_mode = MODE_BINARY;
        out_if.ready = 1'b0;
        mode_bin = MODE_BINARY;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 0;
        hold_left = 0;
        errors = 0;
        quiet_cycles = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_binary_directed();
        test_text_directed();
        test_random_traffic(16, 63, 116);
        test_random_traffic(63, 16, 116);
        test_random_traffic(0, 0, 116);
        test_output_stall();

        repeat (30) @(posedge i_clk);
        if (errors == 0 && expected_bytes.size() == 0) begin
            $display("signed_int_varint_or_decimal_encoder_top: match");
        end else begin
            $display("signed_int_varint_or_decimal_encoder_top: mismatch");
        end
        $finish;
    end

endmodule

### files.f
rtl/sivde_pkg.sv
rtl/sivde_if.sv
rtl/sivde_front.sv
rtl/sivde_queue.sv
rtl/sivde_back.sv
rtl/signed_int_varint_or_decimal_encoder_top.sv
test/testbench.sv
